// File: rtl/core/u8d_pkg.sv
// u8d_pkg: shared types for the utf-8 code point decoder
package u8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int MAX_RES = 3;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            raw_fallback;
    } t_result;

    // one queued job: up to three results caused by one input word
    typedef struct packed {
        logic [1:0]                num;
        t_result [MAX_RES-1:0]     res;
    } t_job;

endpackage

// File: rtl/core/u8d_in_if.sv
// u8d_in_if: byte input channel
interface u8d_in_if;
    import u8d_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

// File: rtl/core/u8d_out_if.sv
// u8d_out_if: code point output channel
interface u8d_out_if;
    import u8d_pkg::*;

    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            raw_fallback;
    logic            last_of_run;

    modport source (output valid, output code_point, output raw_fallback,
                    output last_of_run, input ready);
    modport sink   (input valid, input code_point, input raw_fallback,
                    input last_of_run, output ready);
endinterface

// File: rtl/core/u8d_front.sv
// u8d_front: accepts bytes, tracks open sequences and builds result jobs
module u8d_front
    import u8d_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    u8d_in_if.sink i_in,
    input  logic   i_q_ready,
    output logic   o_push,
    output t_job   o_job
);

    typedef enum logic [1:0] {
        SEQ_ONE,
        SEQ_TWO,
        SEQ_THREE,
        SEQ_FOUR
    } t_seq;

    function automatic t_seq seq_of(input logic [BYTE_W-1:0] c);
        t_seq s;
        priority if (c[7] == 1'b0)        s = SEQ_ONE;
        else if (c[7:5] == 3'b110)        s = SEQ_TWO;
        else if (c[7:4] == 4'b1110)       s = SEQ_THREE;
        else if (c[7:3] == 5'b11110)      s = SEQ_FOUR;
        else                              s = SEQ_ONE;
        return s;
    endfunction

    function automatic t_result raw_of(input logic [BYTE_W-1:0] c, input logic raw);
        t_result r;
        r.code_point   = {{(CP_W-BYTE_W){1'b0}}, c};
        r.raw_fallback = raw;
        return r;
    endfunction

    logic [BYTE_W-1:0] r_open_lead, n_open_lead;
    logic [1:0]        r_held_cnt,  n_held_cnt;
    logic [BYTE_W-1:0] r_held0, n_held0;
    logic [BYTE_W-1:0] r_held1, n_held1;

    logic              accept;
    logic [BYTE_W-1:0] b;
    logic              done;
    logic [CP_W-1:0]   joined;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;
    assign b          = i_in.text_byte;

    always_comb begin
        done   = 1'b1;
        joined = '0;
        unique case (seq_of(r_open_lead))
            SEQ_TWO: begin
                joined = {10'd0, r_open_lead[4:0], b[5:0]};
            end
            SEQ_THREE: begin
                done   = (r_held_cnt != 2'd0);
                joined = {5'd0, r_open_lead[3:0], r_held0[5:0], b[5:0]};
            end
            SEQ_FOUR: begin
                done   = r_held_cnt[1];
                joined = {r_open_lead[2:0], r_held0[5:0], r_held1[5:0], b[5:0]};
            end
            SEQ_ONE: begin
                joined = {18'd0, r_open_lead[2:0]};
            end
        endcase
    end

    always_comb begin
        n_open_lead = r_open_lead;
        n_held_cnt  = r_held_cnt;
        n_held0     = r_held0;
        n_held1     = r_held1;
        o_push      = 1'b0;
        o_job       = '0;
        if (accept) begin
            if (b == '0) begin
                n_open_lead = '0;
                n_held_cnt  = '0;
                if (r_open_lead != '0) begin
                    o_push       = 1'b1;
                    o_job.res[0] = raw_of(r_open_lead, 1'b1);
                    if (r_held_cnt == 2'd0) begin
                        o_job.num = 2'd1;
                    end else if (r_held_cnt == 2'd1) begin
                        o_job.num    = 2'd2;
                        o_job.res[1] = raw_of(r_held0, r_held0[7]);
                    end else if (!r_held0[7]) begin
                        o_job.num    = 2'd3;
                        o_job.res[1] = raw_of(r_held0, 1'b0);
                        o_job.res[2] = raw_of(r_held1, r_held1[7]);
                    end else if (seq_of(r_held0) == SEQ_TWO) begin
                        o_job.num                 = 2'd2;
                        o_job.res[1].code_point   = {10'd0, r_held0[4:0], r_held1[5:0]};
                        o_job.res[1].raw_fallback = 1'b0;
                    end else begin
                        o_job.num    = 2'd3;
                        o_job.res[1] = raw_of(r_held0, 1'b1);
                        o_job.res[2] = raw_of(r_held1, r_held1[7]);
                    end
                end
            end else if (r_open_lead == '0) begin
                if (!b[7]) begin
                    o_push       = 1'b1;
                    o_job.num    = 2'd1;
                    o_job.res[0] = raw_of(b, 1'b0);
                end else if (seq_of(b) == SEQ_ONE) begin
                    o_push       = 1'b1;
                    o_job.num    = 2'd1;
                    o_job.res[0] = raw_of(b, 1'b1);
                end else begin
                    n_open_lead = b;
                    n_held_cnt  = '0;
                end
            end else if (done) begin
                o_push                    = 1'b1;
                o_job.num                 = 2'd1;
                o_job.res[0].code_point   = joined;
                o_job.res[0].raw_fallback = 1'b0;
                n_open_lead               = '0;
                n_held_cnt                = '0;
            end else begin
                if (r_held_cnt == 2'd0) begin
                    n_held0 = b;
                end else begin
                    n_held1 = b;
                end
                n_held_cnt = r_held_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_lead <= '0;
            r_held_cnt  <= '0;
        end else begin
            r_open_lead <= n_open_lead;
            r_held_cnt  <= n_held_cnt;
        end
        r_held0 <= n_held0;
        r_held1 <= n_held1;
    end

endmodule

// File: rtl/core/u8d_queue.sv
// u8d_queue: short job queue between front and back
module u8d_queue
    import u8d_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    output logic o_ready,
    output logic o_valid,
    output t_job o_head,
    input  logic i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

// File: rtl/core/u8d_back.sv
// u8d_back: steps through the results of each queued job
module u8d_back
    import u8d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_job       i_head,
    output logic       o_pop,
    u8d_out_if.source  o_out
);

    logic [1:0] r_idx, n_idx;
    logic       last;
    logic       accept;
    t_result    cur;

    always_comb begin
        unique case (r_idx)
            2'd1:    cur = i_head.res[1];
            2'd2:    cur = i_head.res[2];
            default: cur = i_head.res[0];
        endcase
    end

    assign last               = (r_idx == i_head.num - 2'd1);
    assign accept             = i_valid && o_out.ready;
    assign o_pop              = accept && last;
    assign o_out.valid        = i_valid;
    assign o_out.code_point   = cur.code_point;
    assign o_out.raw_fallback = cur.raw_fallback;
    assign o_out.last_of_run  = last;

    always_comb begin
        n_idx = r_idx;
        if (accept) begin
            n_idx = last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

// File: rtl/core/utf8_codepoint_decoder.sv
// utf8_codepoint_decoder: streaming utf-8 byte to code point decoder, top level
//
//  channel  dir  payload                                  handshake
//  i_in     in   text_byte[7:0]                           valid/ready
//  o_out    out  code_point[20:0] raw_fallback last_of_run valid/ready
//
// one byte is taken per cycle while the job queue has room; a byte gives at
// most one job, so the front pushes at most one job per cycle
// the back sends one result word per cycle while o_out is ready; a zero byte that
// closes an open sequence gives up to three words, so the back can hold the front
// once QUEUE_DEPTH jobs are waiting
// synchronous active-low reset clears the open sequence and empties the queue
module utf8_codepoint_decoder
    import u8d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    u8d_in_if.sink     i_in,
    u8d_out_if.source  o_out
);

    logic push;
    t_job push_job;
    logic q_ready;
    logic q_valid;
    t_job q_head;
    logic q_pop;

    u8d_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_job     (push_job)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_ready    (q_ready),
        .o_valid    (q_valid),
        .o_head     (q_head),
        .i_pop      (q_pop)
    );

    u8d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

// File: verif/utf8_codepoint_decoder_tb.sv
// utf8_codepoint_decoder_tb: directed and random byte streams checked against a decoder model
module utf8_codepoint_decoder_tb;
    import u8d_pkg::*;

    localparam int RAND_BYTES  = 95;
    localparam int DIR_ROWS    = 25;
    localparam int PAUSE_AT    = DIR_ROWS + 60;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_LEN    = 48;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 8;

    typedef enum logic [1:0] {
        EXP_PREDICT,
        EXP_NONE,
        EXP_ONE
    } t_exp_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        t_exp_kind         kind;
        logic [CP_W-1:0]   cp;
        logic              raw;
    } t_text_row;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            raw;
        logic            last;
    } t_cp_expect;

    localparam t_text_row DIR_TAB [DIR_ROWS] = '{
        '{8'h00, EXP_NONE,    21'h000000, 1'b0},
        '{8'h01, EXP_ONE,     21'h000001, 1'b0},
        '{8'h7F, EXP_ONE,     21'h00007F, 1'b0},
        '{8'h80, EXP_ONE,     21'h000080, 1'b1},
        '{8'hBF, EXP_ONE,     21'h0000BF, 1'b1},
        '{8'hF8, EXP_ONE,     21'h0000F8, 1'b1},
        '{8'hFF, EXP_ONE,     21'h0000FF, 1'b1},
        '{8'hC0, EXP_NONE,    21'h000000, 1'b0},
        '{8'h80, EXP_ONE,     21'h000000, 1'b0},
        '{8'hDF, EXP_NONE,    21'h000000, 1'b0},
        '{8'hFF, EXP_ONE,     21'h0007FF, 1'b0},
        '{8'hEF, EXP_NONE,    21'h000000, 1'b0},
        '{8'hBF, EXP_NONE,    21'h000000, 1'b0},
        '{8'hBF, EXP_ONE,     21'h00FFFF, 1'b0},
        '{8'hF7, EXP_NONE,    21'h000000, 1'b0},
        '{8'hBF, EXP_NONE,    21'h000000, 1'b0},
        '{8'hBF, EXP_NONE,    21'h000000, 1'b0},
        '{8'hBF, EXP_ONE,     21'h1FFFFF, 1'b0},
        '{8'hF0, EXP_NONE,    21'h000000, 1'b0},
        '{8'hC5, EXP_NONE,    21'h000000, 1'b0},
        '{8'h85, EXP_NONE,    21'h000000, 1'b0},
        '{8'h00, EXP_PREDICT, 21'h000000, 1'b0},
        '{8'hE0, EXP_NONE,    21'h000000, 1'b0},
        '{8'hC3, EXP_NONE,    21'h000000, 1'b0},
        '{8'h00, EXP_PREDICT, 21'h000000, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8d_in_if  in_ch ();
    u8d_out_if out_ch ();

    utf8_codepoint_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_text_row  text_stim [$];
    t_cp_expect cp_expect_q [$];

    // model of the open sequence
    logic [7:0] seq_lead;
    logic [1:0] seq_count;
    logic [7:0] seq_held [2];

    int n_accepted = 0;
    int n_words    = 0;
    int n_raw      = 0;
    int n_triple   = 0;
    int n_errors   = 0;

    function automatic int seq_length(input logic [7:0] c);
        if (c < 8'h80) return 1;
        if ((c & 8'hE0) == 8'hC0) return 2;
        if ((c & 8'hF0) == 8'hE0) return 3;
        if ((c & 8'hF8) == 8'hF0) return 4;
        return 1;
    endfunction

    function automatic logic [CP_W-1:0] join_seq(input logic [7:0] lead, input logic [7:0] t0,
                                                 input logic [7:0] t1, input logic [7:0] t2,
                                                 input int len);
        logic [CP_W-1:0] v;
        if (len == 2) v = CP_W'(lead[4:0]);
        else if (len == 3) v = CP_W'(lead[3:0]);
        else v = CP_W'(lead[2:0]);
        v = (v << 6) | CP_W'(t0[5:0]);
        if (len >= 3) v = (v << 6) | CP_W'(t1[5:0]);
        if (len == 4) v = (v << 6) | CP_W'(t2[5:0]);
        return v;
    endfunction

    function automatic t_cp_expect cp_word(input logic [CP_W-1:0] cp, input logic raw);
        t_cp_expect w;
        w.cp   = cp;
        w.raw  = raw;
        w.last = 1'b0;
        return w;
    endfunction

    function automatic t_text_row rand_row(input logic [7:0] b);
        t_text_row r;
        r.text_byte = b;
        r.kind      = EXP_PREDICT;
        r.cp        = '0;
        r.raw       = 1'b0;
        return r;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input bit keep);
        t_cp_expect outs [3];
        logic [7:0] tail [3];
        logic [7:0] c;
        int n;
        int i;
        int len;
        int cnt;
        n = 0;
        tail[0] = 8'h00;
        tail[1] = 8'h00;
        tail[2] = 8'h00;
        cnt = (seq_count > 2) ? 2 : int'(seq_count);
        if (b == 8'h00) begin
            if (seq_lead != 8'h00) begin
                outs[n] = cp_word(CP_W'(seq_lead), 1'b1);
                n++;
                i = 0;
                while (i < cnt) begin
                    c = seq_held[i];
                    len = seq_length(c);
                    if (c < 8'h80) begin
                        outs[n] = cp_word(CP_W'(c), 1'b0);
                        i++;
                    end else if (len > 1 && i + len <= cnt) begin
                        outs[n] = cp_word(join_seq(c, seq_held[1], 8'h00, 8'h00, len), 1'b0);
                        i += len;
                    end else begin
                        outs[n] = cp_word(CP_W'(c), 1'b1);
                        i++;
                    end
                    n++;
                end
            end
            seq_lead  = 8'h00;
            seq_count = 2'd0;
        end else if (seq_lead == 8'h00) begin
            len = seq_length(b);
            if (b < 8'h80) begin
                outs[n] = cp_word(CP_W'(b), 1'b0);
                n++;
            end else if (len == 1) begin
                outs[n] = cp_word(CP_W'(b), 1'b1);
                n++;
            end else begin
                seq_lead  = b;
                seq_count = 2'd0;
            end
        end else begin
            len = seq_length(seq_lead);
            if (cnt + 2 >= len) begin
                for (i = 0; i < cnt; i++) tail[i] = seq_held[i];
                tail[cnt] = b;
                outs[n] = cp_word(join_seq(seq_lead, tail[0], tail[1], tail[2], len), 1'b0);
                n++;
                seq_lead  = 8'h00;
                seq_count = 2'd0;
            end else begin
                seq_held[cnt] = b;
                seq_count     = 2'(cnt + 1);
            end
        end
        if (n > 0) outs[n-1].last = 1'b1;
        if (n == 3) n_triple++;
        if (keep) begin
            for (i = 0; i < n; i++) cp_expect_q.push_back(outs[i]);
        end
    endtask

    // accepted words on both channels
    always @(posedge i_clk) begin
        t_text_row  row;
        t_cp_expect want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                row = text_stim[n_accepted];
                decode_byte(in_ch.text_byte, row.kind == EXP_PREDICT);
                if (row.kind == EXP_ONE) begin
                    want      = cp_word(row.cp, row.raw);
                    want.last = 1'b1;
                    cp_expect_q.push_back(want);
                end
                n_accepted++;
            end
            if (out_ch.valid && out_ch.ready) begin
                n_words++;
                if (out_ch.raw_fallback) n_raw++;
                if (cp_expect_q.size() == 0) begin
                    $error("unexpected word: code_point %h raw_fallback %b last_of_run %b",
                           out_ch.code_point, out_ch.raw_fallback, out_ch.last_of_run);
                    n_errors++;
                end else begin
                    want = cp_expect_q.pop_front();
                    if (out_ch.code_point !== want.cp) begin
                        $error("code_point: expected %h, got %h", want.cp, out_ch.code_point);
                        n_errors++;
                    end
                    if (out_ch.raw_fallback !== want.raw) begin
                        $error("raw_fallback: expected %b, got %b", want.raw,
                               out_ch.raw_fallback);
                        n_errors++;
                    end
                    if (out_ch.last_of_run !== want.last) begin
                        $error("last_of_run: expected %b, got %b", want.last,
                               out_ch.last_of_run);
                        n_errors++;
                    end
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    initial begin : rx_side
        int cyc;
        int mode;
        logic [15:0] pat;
        out_ch.ready <= 1'b0;
        cyc  = 0;
        mode = 0;
        pat  = 16'hFFFF;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc == HOLD_AT) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end else begin
                if (cyc % 64 == 0) begin
                    mode = $urandom_range(0, 2);
                    pat  = 16'($urandom);
                end
                unique case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= pat[cyc % 16];
                    default: out_ch.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
            else quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : tx_side
        int i;
        int j;
        int k;
        int tok;
        int len;
        int hold_gap;
        int burst_left;
        bit pause;
        logic [7:0] lead;
        in_ch.valid     <= 1'b0;
        in_ch.text_byte <= 8'h00;
        i_rst_n         <= 1'b0;
        seq_lead  = 8'h00;
        seq_count = 2'd0;
        seq_held[0] = 8'h00;
        seq_held[1] = 8'h00;

        foreach (DIR_TAB[r]) text_stim.push_back(DIR_TAB[r]);

        // mostly well formed sequences, mixed with truncated ones, stray leads, zero bytes and noise
        while (text_stim.size() < DIR_ROWS + RAND_BYTES) begin
            tok = $urandom_range(0, 99);
            if (tok < 30) begin
                text_stim.push_back(rand_row(8'($urandom_range(1, 127))));
            end else if (tok < 80) begin
                len = $urandom_range(2, 4);
                if (len == 2) lead = {3'b110, 5'($urandom)};
                else if (len == 3) lead = {4'b1110, 4'($urandom)};
                else lead = {5'b11110, 3'($urandom)};
                text_stim.push_back(rand_row(lead));
                k = (tok < 62) ? len - 1 : $urandom_range(0, len - 2);
                for (j = 0; j < k; j++) begin
                    if (tok < 62) text_stim.push_back(rand_row({2'b10, 6'($urandom)}));
                    else text_stim.push_back(rand_row(8'($urandom_range(1, 255))));
                end
                if (k < len - 1) text_stim.push_back(rand_row(8'h00));
            end else if (tok < 88) begin
                if ($urandom_range(0, 1) == 1)
                    text_stim.push_back(rand_row(8'($urandom_range(8'h80, 8'hBF))));
                else
                    text_stim.push_back(rand_row(8'($urandom_range(8'hF8, 8'hFF))));
            end else if (tok < 94) begin
                text_stim.push_back(rand_row(8'h00));
            end else begin
                text_stim.push_back(rand_row(8'($urandom_range(0, 255))));
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        burst_left = 0;
        for (i = 0; i < text_stim.size(); i++) begin
            hold_gap = 0;
            if (burst_left == 0) begin
                hold_gap   = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 20);
            end
            pause = (i == PAUSE_AT);
            if (hold_gap != 0 || pause) begin
                in_ch.valid <= 1'b0;
                repeat (hold_gap) @(posedge i_clk);
                if (pause) begin
                    do @(posedge i_clk);
                    while (n_accepted != i || cp_expect_q.size() != 0);
                end
            end
            in_ch.valid     <= 1'b1;
            in_ch.text_byte <= text_stim[i].text_byte;
            do @(posedge i_clk); while (!in_ch.ready);
            burst_left--;
        end
        in_ch.valid <= 1'b0;

        while (n_accepted != text_stim.size() || cp_expect_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes of text; %0d code point words came back, %0d of them raw",
                 n_accepted, n_words, n_raw);
        $display("%0d end-of-text flushes produced three words each", n_triple);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
